@@ rtl/alu_compare_branch_unit_assert.svh @@
// assertion macros included by alu_compare_branch_unit.sv
`ifndef ALU_COMPARE_BRANCH_UNIT_ASSERT_SVH
`define ALU_COMPARE_BRANCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ACBU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ACBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ACBU_ASSERT(lbl, clk, rst_n, prop, msg)

`define ACBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/acbu_pkg.sv @@
package acbu_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 5;
    localparam int FLAG_W = 5;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(DATA_W - 1);

    localparam int FLAG_EQ  = 0;
    localparam int FLAG_GT  = 1;
    localparam int FLAG_LT  = 2;
    localparam int FLAG_SGT = 3;
    localparam int FLAG_SLT = 4;

    localparam logic [DATA_W-1:0] MASK8  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK16 = 32'h0000_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PASS   = 5'd0,
        OP_MASK8  = 5'd1,
        OP_MASK16 = 5'd2,
        OP_SEXT8  = 5'd3,
        OP_SEXT16 = 5'd4,
        OP_ADD    = 5'd5,
        OP_SUB    = 5'd6,
        OP_MUL    = 5'd7,
        OP_DIV    = 5'd8,
        OP_MOD    = 5'd9,
        OP_MIN    = 5'd10,
        OP_MAX    = 5'd11,
        OP_LNOT   = 5'd12,
        OP_CMP    = 5'd13,
        OP_JMP    = 5'd14,
        OP_JE     = 5'd15,
        OP_JNE    = 5'd16,
        OP_JA     = 5'd17,
        OP_JSA    = 5'd18,
        OP_JB     = 5'd19,
        OP_JSB    = 5'd20
    } op_t;

    typedef enum logic [1:0] {
        LK_MUL,
        LK_DIV,
        LK_MOD
    } long_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       step;
        long_kind_t kind;
    } iter_ctrl_t;

    typedef struct packed {
        logic busy;
        logic fin;
    } seq_status_t;

endpackage

@@ rtl/acbu_iter.sv @@
module acbu_iter
    import acbu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  iter_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] load_a,
    input  logic [DATA_W-1:0] load_b,
    output logic [DATA_W-1:0] iter_result
);

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] b_reg, b_next;
    long_kind_t        kind_reg, kind_next;

    logic [DATA_W:0] add_x;
    logic [DATA_W:0] add_y;
    logic            add_cin;
    logic [DATA_W:0] add_sum;
    logic            is_div;

    assign is_div = (kind_reg != LK_MUL);

    // one shared adder: shift-add for multiply, trial subtract for divide
    always_comb
    begin
        if (is_div)
        begin
            add_x   = {acc_reg, q_reg[DATA_W-1]};
            add_y   = ~{1'b0, b_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {1'b0, acc_reg[DATA_W-2:0], 1'b0};
            add_y   = {1'b0, b_reg};
            add_cin = 1'b0;
        end
        add_sum = add_x + add_y + {{DATA_W{1'b0}}, add_cin};
    end

    always_comb
    begin
        acc_next  = acc_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        kind_next = kind_reg;
        if (ctrl.load)
        begin
            acc_next  = '0;
            q_next    = load_a;
            b_next    = load_b;
            kind_next = ctrl.kind;
        end
        else if (ctrl.step)
        begin
            if (is_div)
            begin
                if (!add_sum[DATA_W])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = add_x[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = q_reg[DATA_W-1] ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= LK_MUL;
        end
        else
        begin
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
    end

    assign iter_result = (kind_reg == LK_DIV) ? q_reg : acc_reg;

endmodule

@@ rtl/acbu_seq.sv @@
module acbu_seq
    import acbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  long_kind_t  start_kind,
    output iter_ctrl_t  ctrl,
    output seq_status_t status
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ITER;
                    cnt_next   = '0;
                end
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.kind   = start_kind;
        status.busy = 1'b1;
        status.fin  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load   = start;
                status.busy = 1'b0;
            end
            ST_ITER:
            begin
                ctrl.step = 1'b1;
            end
            ST_FIN:
            begin
                status.fin = 1'b1;
            end
            default:
            begin
                status.busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/alu_compare_branch_unit.sv @@
// execute unit: one operation per input transaction, one result transaction back.
// input channel: in_valid/in_ready with req_type, first_operand, second_operand.
// output channel: out_valid/out_ready with result_value, result_write, jump_taken,
// jump_target and divide_fault, held in an output register until taken.
// moves, masks, extends, add, sub, min, max, lnot, compare, jumps and divide by
// zero are done directly: the result is valid the cycle after acceptance, and
// a new transaction is taken every cycle while the receiver keeps up.
// multiply, divide and modulo run 32 passes through one shared 33-bit adder
// under a small sequencer, and in_ready stays low while the sequencer is busy.
// a transaction is accepted only when the output register is empty or being
// drained in the same cycle, so a stalled receiver holds in_ready low.
// compare updates the five kept flags; conditional jumps read them.
// reset clears the flags, the output valid and the sequencer.
module alu_compare_branch_unit
    import acbu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   req_type,
    input  logic [DATA_W-1:0] first_operand,
    input  logic [DATA_W-1:0] second_operand,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] result_value,
    output logic              result_write,
    output logic              jump_taken,
    output logic [DATA_W-1:0] jump_target,
    output logic              divide_fault
);

    `include "alu_compare_branch_unit_assert.svh"

    op_t               op;
    logic              accept;
    logic              long_op;
    long_kind_t        long_kind;
    logic              b_zero;
    iter_ctrl_t        ctrl;
    seq_status_t       status;
    logic [DATA_W-1:0] iter_result;

    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [FLAG_W-1:0] cmp_flags;

    logic [DATA_W-1:0] val;
    logic              wr;
    logic              jt;
    logic              fault;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              write_reg, write_next;
    logic              taken_reg, taken_next;
    logic [DATA_W-1:0] target_reg, target_next;
    logic              fault_reg, fault_next;

    assign op       = op_t'(req_type);
    assign b_zero   = (second_operand == '0);
    assign in_ready = !status.busy && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign long_op  = (op == OP_MUL) || ((op inside {OP_DIV, OP_MOD}) && !b_zero);

    always_comb
    begin
        case (op)
            OP_DIV:  long_kind = LK_DIV;
            OP_MOD:  long_kind = LK_MOD;
            default: long_kind = LK_MUL;
        endcase
    end

    acbu_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && long_op),
        .start_kind (long_kind),
        .ctrl       (ctrl),
        .status     (status)
    );

    acbu_iter u_iter (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .load_a      (first_operand),
        .load_b      (second_operand),
        .iter_result (iter_result)
    );

    // signed order by flipping the sign bits
    always_comb
    begin
        cmp_flags           = '0;
        cmp_flags[FLAG_EQ]  = (first_operand == second_operand);
        cmp_flags[FLAG_GT]  = (first_operand > second_operand);
        cmp_flags[FLAG_LT]  = (first_operand < second_operand);
        cmp_flags[FLAG_SGT] = ({~first_operand[DATA_W-1], first_operand[DATA_W-2:0]} >
                               {~second_operand[DATA_W-1], second_operand[DATA_W-2:0]});
        cmp_flags[FLAG_SLT] = ({~first_operand[DATA_W-1], first_operand[DATA_W-2:0]} <
                               {~second_operand[DATA_W-1], second_operand[DATA_W-2:0]});
    end

    // short operations, computed combinationally
    always_comb
    begin
        val   = '0;
        wr    = 1'b0;
        jt    = 1'b0;
        fault = 1'b0;
        case (op)
            OP_PASS:
            begin
                val = second_operand;
                wr  = 1'b1;
            end
            OP_MASK8:
            begin
                val = second_operand & MASK8;
                wr  = 1'b1;
            end
            OP_MASK16:
            begin
                val = second_operand & MASK16;
                wr  = 1'b1;
            end
            OP_SEXT8:
            begin
                val = {{(DATA_W-8){second_operand[7]}}, second_operand[7:0]};
                wr  = 1'b1;
            end
            OP_SEXT16:
            begin
                val = {{(DATA_W-16){second_operand[15]}}, second_operand[15:0]};
                wr  = 1'b1;
            end
            OP_ADD:
            begin
                val = first_operand + second_operand;
                wr  = 1'b1;
            end
            OP_SUB:
            begin
                val = first_operand - second_operand;
                wr  = 1'b1;
            end
            OP_DIV, OP_MOD:
            begin
                fault = b_zero;
            end
            OP_MIN:
            begin
                val = (first_operand < second_operand) ? first_operand : second_operand;
                wr  = 1'b1;
            end
            OP_MAX:
            begin
                val = (first_operand > second_operand) ? first_operand : second_operand;
                wr  = 1'b1;
            end
            OP_LNOT:
            begin
                val = {{(DATA_W-1){1'b0}}, b_zero};
                wr  = 1'b1;
            end
            OP_JMP: jt = 1'b1;
            OP_JE:  jt = flags_reg[FLAG_EQ];
            OP_JNE: jt = !flags_reg[FLAG_EQ];
            OP_JA:  jt = flags_reg[FLAG_GT];
            OP_JSA: jt = flags_reg[FLAG_SGT];
            OP_JB:  jt = flags_reg[FLAG_LT];
            OP_JSB: jt = flags_reg[FLAG_SLT];
            default:
            begin
                val = '0;
            end
        endcase
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (accept && (op == OP_CMP))
        begin
            flags_next = cmp_flags;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        write_next     = write_reg;
        taken_next     = taken_reg;
        target_next    = target_reg;
        fault_next     = fault_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (status.fin)
        begin
            out_valid_next = 1'b1;
            value_next     = iter_result;
            write_next     = 1'b1;
            taken_next     = 1'b0;
            target_next    = '0;
            fault_next     = 1'b0;
        end
        else if (accept && !long_op)
        begin
            out_valid_next = 1'b1;
            value_next     = val;
            write_next     = wr;
            taken_next     = jt;
            target_next    = jt ? second_operand : '0;
            fault_next     = fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        write_reg  <= write_next;
        taken_reg  <= taken_next;
        target_reg <= target_next;
        fault_reg  <= fault_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign result_write = write_reg;
    assign jump_taken   = taken_reg;
    assign jump_target  = target_reg;
    assign divide_fault = fault_reg;

    `ACBU_ASSERT_NEXT(a_long_clears_out, clk, rst_n, accept && long_op, !out_valid_reg,
        "output register still full after a long transaction started")
    `ACBU_ASSERT(a_fin_out_empty, clk, rst_n, !status.fin || !out_valid_reg,
        "iterative result would overwrite a pending transaction")
    `ACBU_ASSERT(a_one_kind, clk, rst_n,
        !out_valid_reg || ($countones({write_reg, taken_reg, fault_reg}) <= 1),
        "result transaction mixes write, jump and fault")
    `ACBU_ASSERT_NEXT(a_flags_hold, clk, rst_n, !(accept && (op == OP_CMP)),
        flags_reg == $past(flags_reg), "flags changed without a compare")

endmodule

@@ tb/tb_alu_compare_branch_unit.sv @@
module tb_alu_compare_branch_unit;
    import acbu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned PAUSE_AT     = 320;
    localparam int          N_DIRECTED   = 25;

    localparam logic [OP_W-1:0] OP_UNDEF_LOW = 5'd21;
    localparam logic [OP_W-1:0] OP_UNDEF_TOP = 5'd31;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              write;
        logic              taken;
        logic [DATA_W-1:0] target;
        logic              fault;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   code;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic              typed;
        result_t           want;
    } row_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t DIV_FAULT = '{32'h0, 1'b0, 1'b0, 32'h0, 1'b1};

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   req_type       = '0;
    logic [DATA_W-1:0] first_operand  = '0;
    logic [DATA_W-1:0] second_operand = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [DATA_W-1:0] result_value;
    logic              result_write;
    logic              jump_taken;
    logic [DATA_W-1:0] jump_target;
    logic              divide_fault;

    logic [FLAG_W-1:0] cmp_flags = '0;
    result_t           results_due [$];
    int unsigned       cycles     = 0;
    int unsigned       errors     = 0;
    int unsigned       burst_left = 0;
    bit                hold_out   = 1'b0;

    row_t directed_rows [N_DIRECTED] = '{
        // flags are clear after reset
        '{OP_JE,     32'h0,         32'h0000_1234, 1'b1, NO_RESULT},
        '{OP_JNE,    32'h0,         32'hDEAD_BEEF, 1'b1, '{32'h0, 1'b0, 1'b1, 32'hDEAD_BEEF, 1'b0}},
        '{OP_JMP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0}},
        '{OP_PASS,   32'h0,         32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_MASK8,  32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0000_00FF, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_MASK16, 32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0000_FFFF, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_SEXT8,  32'h0,         32'h0000_0080, 1'b1, '{32'hFFFF_FF80, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_SEXT16, 32'h0,         32'hFFFF_7FFF, 1'b1, '{32'h0000_7FFF, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_SUB,    32'h0,         32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_MUL,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0}},
        '{OP_DIV,    32'hFFFF_FFFF, 32'h0,         1'b1, DIV_FAULT},
        '{OP_MOD,    32'h1234_5678, 32'h0,         1'b1, DIV_FAULT},
        '{OP_MOD,    32'hFFFF_FFFF, 32'h0000_0007, 1'b0, NO_RESULT},
        '{OP_MIN,    32'h0,         32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{OP_MAX,    32'h0,         32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{OP_LNOT,   32'hFFFF_FFFF, 32'h0,         1'b1, '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0}},
        // unsigned greater but signed lower
        '{OP_CMP,    32'h8000_0000, 32'h0000_0001, 1'b1, NO_RESULT},
        '{OP_JA,     32'h0,         32'h0000_0100, 1'b0, NO_RESULT},
        '{OP_JSA,    32'h0,         32'h0000_0200, 1'b0, NO_RESULT},
        '{OP_JB,     32'h0,         32'h0000_0300, 1'b0, NO_RESULT},
        '{OP_JSB,    32'h0,         32'h0000_0400, 1'b0, NO_RESULT},
        '{OP_CMP,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, NO_RESULT},
        '{OP_JE,     32'h0,         32'h0000_0500, 1'b0, NO_RESULT},
        '{OP_UNDEF_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT}
    };

    alu_compare_branch_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value),
        .result_write   (result_write),
        .jump_taken     (jump_taken),
        .jump_target    (jump_target),
        .divide_fault   (divide_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t execute(logic [OP_W-1:0] code, logic [DATA_W-1:0] a,
                                        logic [DATA_W-1:0] b);
        result_t r;
        logic    cond;
        logic    is_jump;
        r       = '0;
        cond    = 1'b0;
        is_jump = 1'b0;
        case (code)
            OP_PASS:   begin r.value = b;          r.write = 1'b1; end
            OP_MASK8:  begin r.value = b & MASK8;  r.write = 1'b1; end
            OP_MASK16: begin r.value = b & MASK16; r.write = 1'b1; end
            OP_SEXT8:  begin r.value = {{24{b[7]}}, b[7:0]};   r.write = 1'b1; end
            OP_SEXT16: begin r.value = {{16{b[15]}}, b[15:0]}; r.write = 1'b1; end
            OP_ADD:    begin r.value = a + b;      r.write = 1'b1; end
            OP_SUB:    begin r.value = a - b;      r.write = 1'b1; end
            OP_MUL:    begin r.value = a * b;      r.write = 1'b1; end
            OP_DIV:
            begin
                if (b == '0) r.fault = 1'b1;
                else begin r.value = a / b; r.write = 1'b1; end
            end
            OP_MOD:
            begin
                if (b == '0) r.fault = 1'b1;
                else begin r.value = a % b; r.write = 1'b1; end
            end
            OP_MIN:    begin r.value = (a < b) ? a : b; r.write = 1'b1; end
            OP_MAX:    begin r.value = (a > b) ? a : b; r.write = 1'b1; end
            OP_LNOT:   begin r.value = (b == '0) ? 32'd1 : 32'd0; r.write = 1'b1; end
            OP_CMP:
            begin
                cmp_flags[FLAG_EQ]  = (a == b);
                cmp_flags[FLAG_GT]  = (a > b);
                cmp_flags[FLAG_LT]  = (a < b);
                cmp_flags[FLAG_SGT] = ($signed(a) > $signed(b));
                cmp_flags[FLAG_SLT] = ($signed(a) < $signed(b));
            end
            OP_JMP:    begin is_jump = 1'b1; cond = 1'b1; end
            OP_JE:     begin is_jump = 1'b1; cond = cmp_flags[FLAG_EQ]; end
            OP_JNE:    begin is_jump = 1'b1; cond = !cmp_flags[FLAG_EQ]; end
            OP_JA:     begin is_jump = 1'b1; cond = cmp_flags[FLAG_GT]; end
            OP_JSA:    begin is_jump = 1'b1; cond = cmp_flags[FLAG_SGT]; end
            OP_JB:     begin is_jump = 1'b1; cond = cmp_flags[FLAG_LT]; end
            OP_JSB:    begin is_jump = 1'b1; cond = cmp_flags[FLAG_SLT]; end
            default:   ;
        endcase
        if (is_jump && cond)
        begin
            r.taken  = 1'b1;
            r.target = b;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return DATA_W'($urandom_range(0, 255));
            default: return DATA_W'($urandom());
        endcase
    endfunction

    task automatic offer(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b, input logic typed, input result_t want);
        result_t predicted;
        in_valid       <= 1'b1;
        req_type       <= code;
        first_operand  <= a;
        second_operand <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = execute(code, a, b);
        results_due.push_back(typed ? want : predicted);
    endtask

    // sender bursts with random gaps between them
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap        = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b);
        offer(code, a, b, 1'b0, NO_RESULT);
        pace();
    endtask

    task automatic report(input string field, input logic [DATA_W-1:0] want,
                          input logic [DATA_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls on a rotating pattern, with one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_out = 1'b0;
            end
            else
            begin
                case ((cycles / 101) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ((cycles % 7) >= 3);
                    default: out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{result_value, result_write, jump_taken, jump_target, divide_fault};
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: transaction with nothing pending, actual value %h write %b",
                         $time, got.value, got.write);
                $display("    jump %b target %h fault %b", got.taken, got.target, got.fault);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.value !== want.value)   report("result_value", want.value, got.value);
                if (got.write !== want.write)   report("result_write", DATA_W'(want.write),
                                                       DATA_W'(got.write));
                if (got.taken !== want.taken)   report("jump_taken", DATA_W'(want.taken),
                                                       DATA_W'(got.taken));
                if (got.target !== want.target) report("jump_target", want.target, got.target);
                if (got.fault !== want.fault)   report("divide_fault", DATA_W'(want.fault),
                                                       DATA_W'(got.fault));
            end
        end
    end

    initial
    begin
        int unsigned       sent;
        int unsigned       jumps;
        bit                held;
        bit                paused;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [OP_W-1:0]   code;

        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer(directed_rows[i].code, directed_rows[i].lhs, directed_rows[i].rhs,
                  directed_rows[i].typed, directed_rows[i].want);
            pace();
        end
        settle();

        while (sent < RANDOM_ITEMS)
        begin
            if (!held && sent >= HOLD_AT)
            begin
                hold_out = 1'b1;
                held     = 1'b1;
            end
            if (!paused && sent >= PAUSE_AT)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                // compare followed by jumps, the conditional ones testing its flags
                a = pick_operand();
                b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
                issue(OP_CMP, a, b);
                jumps = $urandom_range(1, 3);
                sent += jumps + 1;
                repeat (jumps)
                    issue(OP_W'($urandom_range(OP_JMP, OP_JSB)), DATA_W'($urandom()),
                          pick_operand());
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                code = OP_W'($urandom_range(OP_UNDEF_LOW, OP_UNDEF_TOP));
                issue(code, pick_operand(), pick_operand());
                sent++;
            end
            else
            begin
                code = OP_W'($urandom_range(OP_PASS, OP_LNOT));
                issue(code, pick_operand(), pick_operand());
                sent++;
            end
        end
        settle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/acbu_pkg.sv
rtl/acbu_iter.sv
rtl/acbu_seq.sv
rtl/alu_compare_branch_unit.sv
tb/tb_alu_compare_branch_unit.sv
